// ----- hw/rtl/rgbhsv_pkg.sv -----
// rgbhsv_pkg: widths, item types and the divider step shared by the rgb to hsv blocks
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rgbhsv_pkg;

    localparam int HUE_FRAC_BITS  = 7;
    localparam int UNIT_FRAC_BITS = 12;

    localparam int PIX_W  = 8;
    localparam int HUE_W  = 16;
    localparam int UNIT_W = 13;
    // sector position before scaling by 60, 0 .. 6*chroma-1
    localparam int SECT_W = 11;
    // divisors are twice an 8 bit value
    localparam int DEN_W  = PIX_W + 1;

    localparam int HUE_Q_W  = 9 + HUE_FRAC_BITS;
    localparam int UNIT_Q_W = UNIT_FRAC_BITS + 1;
    localparam int DIV_STEPS = (HUE_Q_W > UNIT_Q_W) ? HUE_Q_W : UNIT_Q_W;
    localparam int NUM_W = DIV_STEPS + DEN_W;

    localparam int HUE_SECTOR_DEG = 60;
    localparam int HUE_LIMIT = 360 * (2 ** HUE_FRAC_BITS);
    localparam int HUE_MAX   = (2 ** HUE_W) - 1;
    localparam int PIX_FULL  = 255;

    // value is y + round(y/255) with y = max scaled up, round(y/255) = ((y+128)*257) >> 16
    localparam int VAL_ACC_W = 21;
    localparam int VAL_HALF  = 128;
    localparam int VAL_RECIP = 257;
    localparam int VAL_SHIFT = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic [PIX_W-1:0]  maxv;
        logic [PIX_W-1:0]  chroma;
        logic [SECT_W-1:0] sect;
    } fe_item_t;

    typedef struct packed {
        logic [DEN_W-1:0]     rem;
        logic [DIV_STEPS-1:0] bits;
    } div_work_t;

    typedef struct packed {
        div_work_t         hue;
        div_work_t         sat;
        logic [UNIT_W-1:0] val;
        logic [DEN_W-1:0]  hue_den;
        logic [DEN_W-1:0]  sat_den;
        logic              hue_zero;
        logic              sat_zero;
    } stage_t;

    // one restoring step: shift in the next numerator bit, shift out a quotient bit
    function automatic div_work_t div_step(div_work_t w, logic [DEN_W-1:0] den);
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;
        div_work_t      nw;
        trial = {w.rem, w.bits[DIV_STEPS-1]};
        diff  = trial - {1'b0, den};
        ge    = (trial >= {1'b0, den});
        nw.rem  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nw.bits = {w.bits[DIV_STEPS-2:0], ge};
        return nw;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rgbhsv_front.sv -----
// rgbhsv_front: finds max, min and chroma of a pixel and its position within the hue circle
// depends on rgbhsv_pkg
`timescale 1ns / 1ps
`default_nettype none

module rgbhsv_front (
    input  rgbhsv_pkg::pix_t     red,
    input  rgbhsv_pkg::pix_t     green,
    input  rgbhsv_pkg::pix_t     blue,
    output rgbhsv_pkg::fe_item_t item
);
    import rgbhsv_pkg::*;

    logic              red_max;
    logic              green_max;
    logic [PIX_W-1:0]  maxv;
    logic [PIX_W-1:0]  minv;
    logic [PIX_W-1:0]  chroma;
    logic [SECT_W:0]   diff_gb;
    logic [SECT_W-1:0] sect;

    always_comb
    begin
        red_max   = (red >= green) && (red >= blue);
        green_max = !red_max && (green >= blue);
        maxv = red_max ? red : (green_max ? green : blue);
        minv = red;
        if (green < minv)
        begin
            minv = green;
        end
        if (blue < minv)
        begin
            minv = blue;
        end
        chroma  = maxv - minv;
        diff_gb = {{(SECT_W-PIX_W+1){1'b0}}, green} - {{(SECT_W-PIX_W+1){1'b0}}, blue};
        priority if (red_max)
        begin
            // negative offsets wrap once around the six sectors
            if (diff_gb[SECT_W])
            begin
                sect = diff_gb[SECT_W-1:0] + SECT_W'(6) * SECT_W'(chroma);
            end
            else
            begin
                sect = diff_gb[SECT_W-1:0];
            end
        end
        else if (green_max)
        begin
            sect = SECT_W'(2) * SECT_W'(chroma) + SECT_W'(blue) - SECT_W'(red);
        end
        else
        begin
            sect = SECT_W'(4) * SECT_W'(chroma) + SECT_W'(red) - SECT_W'(green);
        end
        item.maxv   = maxv;
        item.chroma = chroma;
        item.sect   = sect;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rgbhsv_queue.sv -----
// rgbhsv_queue: short flop queue between classification and the divider pipeline
// depends on rgbhsv_pkg
`timescale 1ns / 1ps
`default_nettype none

module rgbhsv_queue (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push_valid,
    output logic                  push_ready,
    input  rgbhsv_pkg::fe_item_t  push_item,
    output logic                  pop_valid,
    input  wire                   pop_ready,
    output rgbhsv_pkg::fe_item_t  pop_item
);
    import rgbhsv_pkg::*;

    fe_item_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push = push_valid && push_ready;
    assign pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rgbhsv_back.sv -----
// rgbhsv_back: pipelined restoring dividers for hue and saturation, one quotient bit a stage,
// with value formed up front by a reciprocal multiply; depends on rgbhsv_pkg
`timescale 1ns / 1ps
`default_nettype none

module rgbhsv_back (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  rgbhsv_pkg::fe_item_t item,
    output logic                 out_valid,
    input  wire                  out_ready,
    output logic [rgbhsv_pkg::HUE_W-1:0]  hue,
    output logic [rgbhsv_pkg::UNIT_W-1:0] saturation,
    output logic [rgbhsv_pkg::UNIT_W-1:0] brightness
);
    import rgbhsv_pkg::*;

    stage_t               stage_reg  [DIV_STEPS+1];
    stage_t               stage_next [DIV_STEPS+1];
    logic [DIV_STEPS:0]   valid_reg;
    logic [DIV_STEPS:0]   valid_next;
    logic                 adv;
    logic [NUM_W-1:0]     hue_num;
    logic [NUM_W-1:0]     sat_num;
    logic [UNIT_W-1:0]    val_base;
    logic [VAL_ACC_W-1:0] val_acc;

    // whole pipeline moves together, stalls only when the last beat is held
    assign adv       = !valid_reg[DIV_STEPS] || out_ready;
    assign in_ready  = adv;
    assign out_valid = valid_reg[DIV_STEPS];

    always_comb
    begin
        // numerators are doubled and offset by the divisor to round half up
        hue_num = ((NUM_W'(item.sect) * NUM_W'(HUE_SECTOR_DEG)) << (HUE_FRAC_BITS + 1))
                  + NUM_W'(item.chroma);
        sat_num = (NUM_W'(item.chroma) << (UNIT_FRAC_BITS + 1)) + NUM_W'(item.maxv);

        // max/255 scaled is y*256/255 with y = max scaled by 2^(frac-8)
        val_base = UNIT_W'(item.maxv) << (UNIT_FRAC_BITS - PIX_W);
        val_acc  = (VAL_ACC_W'(val_base) + VAL_ACC_W'(VAL_HALF)) * VAL_ACC_W'(VAL_RECIP);

        stage_next[0].hue.rem  = hue_num[NUM_W-1:DIV_STEPS];
        stage_next[0].hue.bits = hue_num[DIV_STEPS-1:0];
        stage_next[0].sat.rem  = sat_num[NUM_W-1:DIV_STEPS];
        stage_next[0].sat.bits = sat_num[DIV_STEPS-1:0];
        stage_next[0].val      = val_base + UNIT_W'(val_acc[VAL_ACC_W-1:VAL_SHIFT]);
        stage_next[0].hue_den  = {item.chroma, 1'b0};
        stage_next[0].sat_den  = {item.maxv, 1'b0};
        stage_next[0].hue_zero = (item.chroma == '0);
        stage_next[0].sat_zero = (item.maxv == '0);

        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            stage_next[k]     = stage_reg[k-1];
            stage_next[k].hue = div_step(stage_reg[k-1].hue, stage_reg[k-1].hue_den);
            stage_next[k].sat = div_step(stage_reg[k-1].sat, stage_reg[k-1].sat_den);
        end
        valid_next = {valid_reg[DIV_STEPS-1:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k <= DIV_STEPS; k++)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign hue        = stage_reg[DIV_STEPS].hue_zero ? '0
                        : HUE_W'(stage_reg[DIV_STEPS].hue.bits);
    assign saturation = stage_reg[DIV_STEPS].sat_zero ? '0
                        : UNIT_W'(stage_reg[DIV_STEPS].sat.bits);
    assign brightness = stage_reg[DIV_STEPS].val;

endmodule

`default_nettype wire

// ----- hw/rtl/rgb_to_hsv_convert.sv -----
// rgb_to_hsv_convert: top level, 8 bit rgb pixel in, fixed point hue, saturation and value out
// depends on rgbhsv_pkg, rgbhsv_front, rgbhsv_queue, rgbhsv_back
`timescale 1ns / 1ps
`default_nettype none

// Takes one pixel per clock and returns one hsv beat per pixel, in order. Hue is in degrees
// with HUE_FRAC_BITS fraction bits, saturation and brightness are 1.12 fixed point, all rounded
// to nearest. A pixel is classified as it is accepted and parked in a two-entry queue; hue and
// saturation are then formed by a restoring divider pipeline that resolves one quotient bit
// per stage, DIV_STEPS stages (16 at the default widths), while brightness comes from a
// reciprocal multiply and rides along. The throughput is one pixel every cycle as long as the
// output side keeps taking beats.
module rgb_to_hsv_convert (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire  [rgbhsv_pkg::PIX_W-1:0]  red,
    input  wire  [rgbhsv_pkg::PIX_W-1:0]  green,
    input  wire  [rgbhsv_pkg::PIX_W-1:0]  blue,
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic [rgbhsv_pkg::HUE_W-1:0]  hue,
    output logic [rgbhsv_pkg::UNIT_W-1:0] saturation,
    output logic [rgbhsv_pkg::UNIT_W-1:0] brightness
);
    import rgbhsv_pkg::*;

    fe_item_t fe_item;
    fe_item_t q_item;
    logic     q_valid;
    logic     q_ready;

    rgbhsv_front u_front (
        .red   (red),
        .green (green),
        .blue  (blue),
        .item  (fe_item)
    );

    rgbhsv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_item  (fe_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    rgbhsv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .item       (q_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

    // hue stays below a full turn
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (HUE_LIMIT > HUE_MAX) || (32'(hue) < HUE_LIMIT))
        else $error("hue beyond 360 degrees");

    // a black pixel has no saturation and no hue
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (brightness == '0)) |-> ((saturation == '0) && (hue == '0)))
        else $error("black pixel with nonzero hue or saturation");

    // a gray pixel has no hue
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (saturation == '0)) |-> (hue == '0))
        else $error("achromatic pixel with nonzero hue");

endmodule

`default_nettype wire

// ----- verif/tb_rgb_to_hsv_convert.sv -----
// tb_rgb_to_hsv_convert: self-checking testbench for the rgb to hsv converter
// depends on rgbhsv_pkg and rgb_to_hsv_convert; drives a directed table then random pixels
`timescale 1ns / 1ps

module tb_rgb_to_hsv_convert;
    import rgbhsv_pkg::*;

    typedef struct {
        logic [PIX_W-1:0]  r, g, b;
        logic [HUE_W-1:0]  h;
        logic [UNIT_W-1:0] s, v;
        bit                typed;
    } pixel_row_t;

    typedef struct {
        logic [HUE_W-1:0]  h;
        logic [UNIT_W-1:0] s, v;
    } hsv_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [PIX_W-1:0] red = '0, green = '0, blue = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [HUE_W-1:0] hue;
    logic [UNIT_W-1:0] saturation, brightness;

    hsv_t expected_hsv[$];
    int errors = 0;
    int beats_out = 0;
    int send_idle_pct = 24, recv_idle_pct = 60;
    bit hold_off = 1'b0;

    rgb_to_hsv_convert dut (.*);

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic longint unsigned round_div(longint unsigned num, longint unsigned den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic hsv_t predict_hsv(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                         logic [PIX_W-1:0] b);
        longint mx, mn, c, num;
        hsv_t p;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (g < mn) mn = g;
        if (b > mx) mx = b;
        if (b < mn) mn = b;
        c = mx - mn;
        p.v = UNIT_W'(round_div(mx << UNIT_FRAC_BITS, PIX_FULL));
        p.s = (mx > 0) ? UNIT_W'(round_div(c << UNIT_FRAC_BITS, mx)) : '0;
        p.h = '0;
        if (c != 0) begin
            if (r == mx) num = 60 * (longint'(g) - longint'(b));
            else if (g == mx) num = 60 * (2 * c + longint'(b) - longint'(r));
            else num = 60 * (4 * c + longint'(r) - longint'(g));
            if (num < 0) num += 360 * c;
            p.h = HUE_W'(round_div(num << HUE_FRAC_BITS, c));
        end
        return p;
    endfunction

    // valid drops only when the sender idles, so back to back beats keep it high
    task automatic send_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b,
                              hsv_t exp_hsv);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        in_valid <= 1'b1;
        red <= r; green <= g; blue <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_hsv.push_back(exp_hsv);
    endtask

    // receiver side: random stalls plus an optional long hold-off
    always @(posedge clk) begin
        if (rst_n)
            out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        hsv_t e;
        if (rst_n && out_valid && out_ready) begin
            beats_out++;
            if (expected_hsv.size() == 0) begin
                $error("output beat with nothing expected");
                errors++;
            end else begin
                e = expected_hsv.pop_front();
                if (hue !== e.h) begin
                    $error("hue expected %0d actual %0d", e.h, hue); errors++;
                end
                if (saturation !== e.s) begin
                    $error("saturation expected %0d actual %0d", e.s, saturation); errors++;
                end
                if (brightness !== e.v) begin
                    $error("brightness expected %0d actual %0d", e.v, brightness); errors++;
                end
            end
        end
    end

    pixel_row_t pixel_table[] = '{
        '{8'd0,   8'd0,   8'd0,   16'd0,     13'd0,    13'd0,    1'b1},  // black
        '{8'd255, 8'd255, 8'd255, 16'd0,     13'd0,    13'd4096, 1'b1},  // white
        '{8'd128, 8'd128, 8'd128, 16'd0,     13'd0,    13'd0,    1'b0},  // gray
        '{8'd255, 8'd0,   8'd0,   16'd0,     13'd4096, 13'd4096, 1'b1},  // pure red
        '{8'd0,   8'd255, 8'd0,   16'd15360, 13'd4096, 13'd4096, 1'b1},  // pure green
        '{8'd0,   8'd0,   8'd255, 16'd30720, 13'd4096, 13'd4096, 1'b1},  // pure blue
        '{8'd255, 8'd255, 8'd0,   16'd7680,  13'd4096, 13'd4096, 1'b1},  // red/green tie
        '{8'd0,   8'd255, 8'd255, 16'd23040, 13'd4096, 13'd4096, 1'b1},  // green/blue tie
        '{8'd255, 8'd0,   8'd255, 16'd38400, 13'd4096, 13'd4096, 1'b1},  // red/blue tie
        '{8'd255, 8'd0,   8'd1,   16'd0,     13'd0,    13'd0,    1'b0},  // hue wraps near 360
        '{8'd1,   8'd0,   8'd0,   16'd0,     13'd0,    13'd0,    1'b0},
        '{8'd0,   8'd1,   8'd0,   16'd0,     13'd0,    13'd0,    1'b0},
        '{8'd0,   8'd0,   8'd1,   16'd0,     13'd0,    13'd0,    1'b0},
        '{8'd1,   8'd1,   8'd1,   16'd0,     13'd0,    13'd0,    1'b0},
        '{8'd254, 8'd255, 8'd253, 16'd0,     13'd0,    13'd0,    1'b0},
        '{8'd170, 8'd85,  8'd51,  16'd0,     13'd0,    13'd0,    1'b0},
        '{8'd12,  8'd200, 8'd99,  16'd0,     13'd0,    13'd0,    1'b0},
        '{8'd77,  8'd3,   8'd250, 16'd0,     13'd0,    13'd0,    1'b0}
    };

    initial begin
        hsv_t p;
        logic [PIX_W-1:0] r, g, b;
        int hold_cycles;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (pixel_table[i]) begin
            if (pixel_table[i].typed) begin
                p.h = pixel_table[i].h; p.s = pixel_table[i].s; p.v = pixel_table[i].v;
            end else
                p = predict_hsv(pixel_table[i].r, pixel_table[i].g, pixel_table[i].b);
            send_pixel(pixel_table[i].r, pixel_table[i].g, pixel_table[i].b, p);
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 60 : 0;
            recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 24 : 0;
            for (int k = 0; k < 400; k++) begin
                // long receiver hold-off once, sender keeps offering
                if (phase == 2 && k == 50) begin
                    fork
                        begin
                            hold_off = 1'b1;
                            hold_cycles = 0;
                            while (hold_cycles < 60) begin
                                @(posedge clk);
                                hold_cycles++;
                            end
                            hold_off = 1'b0;
                        end
                    join_none
                end
                r = PIX_W'($urandom); g = PIX_W'($urandom); b = PIX_W'($urandom);
                case ($urandom_range(7))
                    0: g = r;
                    1: begin g = r; b = r; end
                    2: b = ($urandom_range(1)) ? 8'd0 : 8'd255;
                    default: ;
                endcase
                send_pixel(r, g, b, predict_hsv(r, g, b));
            end
        end
        in_valid <= 1'b0;

        while (expected_hsv.size() != 0) @(posedge clk);
        repeat (DIV_STEPS + 10) @(posedge clk);
        $display("checked %0d hsv beats: directed corners, then 1200 random pixels", beats_out);
        $display("random pixels under three sender/receiver stall mixes and one long hold-off");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
